// File: hw/rtl/vttp_pkg.sv
// ----------------------------------------------------------------------------
// vttp_pkg
// Types and constants shared by the virtual-time thread picker.
// ----------------------------------------------------------------------------
`default_nettype none

package vttp_pkg;

   localparam int TIME_BITS  = 48;
   localparam int THREAD_W   = 8;
   localparam int NICE_W     = 16;
   localparam int START_W    = 49;
   localparam int KEY_W      = 50;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 176;
   localparam int RSP_DATA_W = 16;

   localparam logic [CMD_W-1:0] CMD_SWITCH  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UPDATE  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NO_KEY    = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic better;
      logic held;
      logic thread_match;
   } scan_hit_type;

endpackage

`default_nettype wire

// File: hw/rtl/vttp_scan_step.sv
// ----------------------------------------------------------------------------
// vttp_scan_step
// Compare unit applied to one table entry per cycle during a scan.
// ----------------------------------------------------------------------------
`default_nettype none

module vttp_scan_step #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic                                  entry_valid,
   input  wire logic [vttp_pkg::KEY_W-1:0]            entry_key,
   input  wire logic [vttp_pkg::TIME_BITS-1:0]        entry_sleep,
   input  wire logic                                  entry_blocked,
   input  wire logic [vttp_pkg::THREAD_W-1:0]         entry_thread,
   input  wire logic [vttp_pkg::TIME_BITS-1:0]        now,
   input  wire logic [vttp_pkg::THREAD_W-1:0]         thread_id,
   input  wire logic [vttp_pkg::KEY_W-1:0]            base_key,
   input  wire logic [vttp_pkg::KEY_W-1:0]            best_key,
   input  wire logic                                  pick_found,
   output vttp_pkg::scan_hit_type                     hit,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]           offset
);
   import vttp_pkg::*;

   localparam int OFF_W = $clog2(TABLE_DEPTH + 1);

   logic [KEY_W-1:0] diff;
   logic             eligible;

   assign diff     = entry_key - base_key;
   assign eligible = entry_valid && !(entry_sleep > now) && !entry_blocked;
   assign offset   = diff[OFF_W-1:0];

   always_comb begin
      hit.better       = eligible && (!pick_found || (entry_key < best_key));
      hit.held         = entry_valid && (diff <= KEY_W'(TABLE_DEPTH));
      hit.thread_match = entry_valid && (entry_thread == thread_id);
   end

endmodule

`default_nettype wire

// File: hw/rtl/virtual_time_thread_picker.sv
// ----------------------------------------------------------------------------
// virtual_time_thread_picker
// Fair thread picker over a key-ordered table of waiting threads.
// ----------------------------------------------------------------------------
// Requests enter on req_* (command in req_tuser, operands in req_tdata) and
// each produces exactly one response on rsp_*. A request passes through a
// setup state, walks the table once through a shared compare unit, one
// entry per cycle, then applies the result in a done state, which waits
// while the output register still holds an unaccepted response. One
// request is in flight at a time, so a new request is not taken until the
// last one has left the done state. req_tready is high only while no
// request is in flight, also while a finished response still waits in the
// output register.
// A stalled receiver holds the response; the next request may be accepted
// and is scanned, but its result is held back until the register frees.
// Reset empties the table, makes the block idle and drops any pending
// response; the block is ready the cycle after reset falls.
// ----------------------------------------------------------------------------
`default_nettype none

module virtual_time_thread_picker #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // now, thread_id, nice, start_key, sleep_until, blocked, zero fill
   input  wire logic [vttp_pkg::REQ_DATA_W-1:0]     req_tdata,
   // command
   input  wire logic [vttp_pkg::CMD_W-1:0]          req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // switched, running_valid, running_thread, status, zero fill
   output logic [vttp_pkg::RSP_DATA_W-1:0]          rsp_tdata
);
   import vttp_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int OFF_W = $clog2(TABLE_DEPTH + 1);

   state_type state_ff, state_in;

   logic [CMD_W-1:0]     cmd_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [THREAD_W-1:0]  thread_ff;
   logic [NICE_W-1:0]    nice_ff;
   logic [START_W-1:0]   start_ff;
   logic [TIME_BITS-1:0] sleep_ff;
   logic                 blocked_ff;
   logic [KEY_W-1:0]     base_ff;

   logic [IDX_W-1:0]       scan_idx_ff;
   logic                   pick_found_ff;
   logic [IDX_W-1:0]       pick_idx_ff;
   logic [KEY_W-1:0]       best_key_ff;
   logic [THREAD_W-1:0]    pick_thread_ff;
   logic [NICE_W-1:0]      pick_nice_ff;
   logic [TIME_BITS-1:0]   pick_last_ff;
   logic [TABLE_DEPTH:0]   held_ff;
   logic                   upd_found_ff;
   logic [IDX_W-1:0]       upd_idx_ff;

   logic [TABLE_DEPTH-1:0] slot_valid_ff;
   logic [KEY_W-1:0]       slot_key_ff    [TABLE_DEPTH];
   logic [THREAD_W-1:0]    slot_thread_ff [TABLE_DEPTH];
   logic [NICE_W-1:0]      slot_nice_ff   [TABLE_DEPTH];
   logic [TIME_BITS-1:0]   slot_last_ff   [TABLE_DEPTH];
   logic [TIME_BITS-1:0]   slot_sleep_ff  [TABLE_DEPTH];
   logic                   slot_blocked_ff[TABLE_DEPTH];

   logic                 run_valid_ff, run_valid_in;
   logic [THREAD_W-1:0]  run_thread_ff, run_thread_in;
   logic [NICE_W-1:0]    run_nice_ff, run_nice_in;
   logic [TIME_BITS-1:0] run_last_ff, run_last_in;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   scan_hit_type     hit;
   logic [OFF_W-1:0] offset;

   logic                   req_fire, done_fire, last_idx;
   logic [TIME_BITS-1:0]   max_tick;
   logic [TABLE_DEPTH-1:0] free_vec;
   logic                   free_any;
   logic [IDX_W-1:0]       free_idx;
   logic [OFF_W-1:0]       first_free_off;
   logic [KEY_W-1:0]       new_key;
   logic                   fill_en, clear_pick, upd_en;
   logic                   sw;
   logic [STATUS_W-1:0]    status;
   logic                   keep;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign done_fire  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign last_idx   = (scan_idx_ff == IDX_W'(TABLE_DEPTH - 1));
   assign max_tick   = (run_last_ff > now_ff) ? run_last_ff : now_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   vttp_scan_step #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_scan_step (
      .entry_valid  (slot_valid_ff[scan_idx_ff]),
      .entry_key    (slot_key_ff[scan_idx_ff]),
      .entry_sleep  (slot_sleep_ff[scan_idx_ff]),
      .entry_blocked(slot_blocked_ff[scan_idx_ff]),
      .entry_thread (slot_thread_ff[scan_idx_ff]),
      .now          (now_ff),
      .thread_id    (thread_ff),
      .base_key     (base_ff),
      .best_key     (best_key_ff),
      .pick_found   (pick_found_ff),
      .hit          (hit),
      .offset       (offset)
   );

   always_comb begin
      free_vec = ~slot_valid_ff;
      if ((cmd_ff == CMD_SWITCH) && pick_found_ff) begin
         free_vec[pick_idx_ff] = 1'b1;
      end
      free_any = |free_vec;
      free_idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            free_idx = IDX_W'(i);
         end
      end
      first_free_off = '0;
      for (int i = TABLE_DEPTH; i >= 0; i--) begin
         if (!held_ff[i]) begin
            first_free_off = OFF_W'(i);
         end
      end
      new_key = base_ff + KEY_W'(first_free_off);
   end

   always_comb begin
      state_in      = state_ff;
      fill_en       = 1'b0;
      clear_pick    = 1'b0;
      upd_en        = 1'b0;
      sw            = 1'b0;
      status        = STATUS_OK;
      keep          = 1'b0;
      run_valid_in  = run_valid_ff;
      run_thread_in = run_thread_ff;
      run_nice_in   = run_nice_ff;
      run_last_in   = run_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (last_idx) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            unique case (cmd_ff)
               CMD_SWITCH: begin
                  keep = pick_found_ff && run_valid_ff && (best_key_ff > base_ff);
                  priority if (keep) begin
                     sw = 1'b0;
                  end else if (run_valid_ff && !pick_found_ff && !free_any) begin
                     status = STATUS_NO_KEY;
                  end else begin
                     sw         = 1'b1;
                     fill_en    = run_valid_ff;
                     clear_pick = pick_found_ff;
                     if (pick_found_ff) begin
                        run_valid_in  = 1'b1;
                        run_thread_in = pick_thread_ff;
                        run_nice_in   = pick_nice_ff;
                        run_last_in   = pick_last_ff;
                     end else begin
                        run_valid_in  = 1'b0;
                        run_thread_in = '0;
                        run_nice_in   = '0;
                        run_last_in   = '0;
                     end
                  end
               end
               CMD_ENQUEUE: begin
                  if (free_any) begin
                     fill_en = 1'b1;
                  end else begin
                     status = STATUS_FULL;
                  end
               end
               CMD_UPDATE: begin
                  if (upd_found_ff) begin
                     upd_en = 1'b1;
                  end else begin
                     status = STATUS_NOT_FOUND;
                  end
               end
               default: begin
                  status = STATUS_OK;
               end
            endcase
            if (!done_fire) begin
               fill_en       = 1'b0;
               clear_pick    = 1'b0;
               upd_en        = 1'b0;
               run_valid_in  = run_valid_ff;
               run_thread_in = run_thread_ff;
               run_nice_in   = run_nice_ff;
               run_last_in   = run_last_ff;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_data_in = {4'b0, status, (run_valid_in ? run_thread_in : '0), run_valid_in, sw};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         slot_valid_ff <= '0;
         run_valid_ff  <= 1'b0;
         run_thread_ff <= '0;
         run_nice_ff   <= '0;
         run_last_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         run_valid_ff  <= run_valid_in;
         run_thread_ff <= run_thread_in;
         run_nice_ff   <= run_nice_in;
         run_last_ff   <= run_last_in;
         if (done_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (clear_pick && !(fill_en && (free_idx == pick_idx_ff))) begin
            slot_valid_ff[pick_idx_ff] <= 1'b0;
         end
         if (fill_en) begin
            slot_valid_ff[free_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (req_fire) begin
         cmd_ff     <= req_tuser;
         now_ff     <= req_tdata[47:0];
         thread_ff  <= req_tdata[55:48];
         nice_ff    <= req_tdata[71:56];
         start_ff   <= req_tdata[120:72];
         sleep_ff   <= req_tdata[168:121];
         blocked_ff <= req_tdata[169];
      end
      if (state_ff == ST_SETUP) begin
         if (cmd_ff == CMD_SWITCH) begin
            base_ff <= KEY_W'(run_nice_ff) + KEY_W'(max_tick);
         end else begin
            base_ff <= KEY_W'(start_ff);
         end
         scan_idx_ff   <= '0;
         pick_found_ff <= 1'b0;
         held_ff       <= '0;
         upd_found_ff  <= 1'b0;
      end
      if (state_ff == ST_SCAN) begin
         scan_idx_ff <= scan_idx_ff + IDX_W'(1);
         if (hit.better) begin
            pick_found_ff  <= 1'b1;
            pick_idx_ff    <= scan_idx_ff;
            best_key_ff    <= slot_key_ff[scan_idx_ff];
            pick_thread_ff <= slot_thread_ff[scan_idx_ff];
            pick_nice_ff   <= slot_nice_ff[scan_idx_ff];
            pick_last_ff   <= slot_last_ff[scan_idx_ff];
         end
         if (hit.held) begin
            held_ff[offset] <= 1'b1;
         end
         if (hit.thread_match && !upd_found_ff) begin
            upd_found_ff <= 1'b1;
            upd_idx_ff   <= scan_idx_ff;
         end
      end
      if (fill_en) begin
         slot_key_ff[free_idx] <= new_key;
         if (cmd_ff == CMD_SWITCH) begin
            slot_thread_ff[free_idx]  <= run_thread_ff;
            slot_nice_ff[free_idx]    <= run_nice_ff;
            slot_last_ff[free_idx]    <= now_ff;
            slot_sleep_ff[free_idx]   <= '0;
            slot_blocked_ff[free_idx] <= 1'b0;
         end else begin
            slot_thread_ff[free_idx]  <= thread_ff;
            slot_nice_ff[free_idx]    <= nice_ff;
            slot_last_ff[free_idx]    <= now_ff;
            slot_sleep_ff[free_idx]   <= sleep_ff;
            slot_blocked_ff[free_idx] <= blocked_ff;
         end
      end
      if (upd_en) begin
         slot_sleep_ff[upd_idx_ff]   <= sleep_ff;
         slot_blocked_ff[upd_idx_ff] <= blocked_ff;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/vttp_checker.sv
// ----------------------------------------------------------------------------
// vttp_checker
// Port-level checks for the virtual-time thread picker.
// ----------------------------------------------------------------------------
`default_nettype none

module vttp_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic [vttp_pkg::CMD_W-1:0]       req_tuser,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [vttp_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import vttp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_no_fast_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response before table scan");

   a_idle_thread: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[9:2] == '0)
      else $error("idle response carries a thread");

   a_full_no_switch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[11:10] == STATUS_FULL || rsp_tdata[11:10] == STATUS_NOT_FOUND)
      |-> !rsp_tdata[0])
      else $error("switch flagged on enqueue or update");

endmodule

bind virtual_time_thread_picker vttp_checker u_vttp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tuser (req_tuser),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

`default_nettype wire
